// ===== rtl/core/snae_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere to ellipse projection package
// Shared widths, register indexes and datapath lane codes.
// ----------------------------------------------------------------------------
package snae_pkg;

    localparam int DATA_W    = 32;
    localparam int RAD_W     = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPC_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPC_Y  = 2'd2;

    localparam int FRAC_BITS_DEF = 16;

    localparam int SQRT_W     = 64;
    localparam int SQRT_STEPS = SQRT_W / 2;
    localparam int ROOT_W     = SQRT_W / 2;

    localparam int DIV_DW    = 34;
    localparam int DIV_QW    = 35;
    localparam int DIV_LANES = 6;

    localparam int LN_RAD = 0;
    localparam int LN_G   = 1;
    localparam int LN_CX  = 2;
    localparam int LN_CY  = 3;
    localparam int LN_RX  = 4;
    localparam int LN_RY  = 5;

endpackage
`default_nettype wire

// ===== rtl/core/snae_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere to ellipse projection channels
// Valid/ready channels for spheres, ellipses and register writes.
// ----------------------------------------------------------------------------
interface snae_in_if;
    import snae_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] nominal_x;
    logic signed [DATA_W-1:0] nominal_y;
    logic        [RAD_W-1:0]  nominal_radius;
    modport source (output valid, nominal_x, nominal_y, nominal_radius, input ready);
    modport sink (input valid, nominal_x, nominal_y, nominal_radius, output ready);
endinterface

interface snae_out_if;
    import snae_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] apparent_x;
    logic signed [DATA_W-1:0] apparent_y;
    logic        [RAD_W-1:0]  minor_radius;
    logic signed [DATA_W-1:0] stretch_x;
    logic signed [DATA_W-1:0] stretch_y;
    logic                     camera_too_low;
    modport source (output valid, apparent_x, apparent_y, minor_radius, stretch_x,
                    stretch_y, camera_too_low, input ready);
    modport sink (input valid, apparent_x, apparent_y, minor_radius, stretch_x,
                  stretch_y, camera_too_low, output ready);
endinterface

interface snae_cfg_if;
    import snae_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sphere_nominal_to_apparent_ellipse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere to apparent ellipse projection
// Maps a nominal sphere centre and radius to the apparent ellipse centre,
// minor semidiameter and stretch vector under a perspective camera.
//
//   Port        Dir   Beat contents
//   i_cfg       in    register index, 32-bit data (spread, optical centre x/y)
//   i_sphere    in    nominal_x, nominal_y, nominal_radius
//   o_ellipse   out   apparent_x/y, minor_radius, stretch_x/y, camera_too_low
//
// One beat is accepted per cycle while the output is not stalled; the path runs
// through two 32-stage square root pipelines and a 35-stage divider in series with
// thirteen further register stages.
// Reset is synchronous and clears the configuration registers and all valid bits.
// A stalled output register freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module sphere_nominal_to_apparent_ellipse #(
    parameter int FRAC_BITS = snae_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    snae_cfg_if.sink   i_cfg,
    snae_in_if.sink    i_sphere,
    snae_out_if.source o_ellipse
);
    import snae_pkg::*;

    typedef struct packed {
        logic        par;
        logic        low;
        logic        negx;
        logic        negy;
        logic        dz;
        logic        gov;
        logic [5:0]  ovf;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [30:0] rin;
        logic [32:0] ax;
        logic [32:0] ay;
        logic [1:0]  hs;
        logic [32:0] den;
        logic [31:0] sd;
        logic [33:0] dd;
        logic [31:0] appx;
        logic [31:0] appy;
        logic [30:0] rsat;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [2:0]  gsh;
        logic [31:0] s;
    } t_side;

    localparam int SW = $bits(t_side);
    localparam logic [35:0] ONE = 36'd1 << FRAC_BITS;

    function automatic logic [31:0] f_sat_add(input logic [31:0] base, input logic neg,
                                              input logic [34:0] mag);
        logic signed [35:0] v;
        if (neg) begin
            v = $signed({{4{base[31]}}, base}) - $signed({1'b0, mag});
        end else begin
            v = $signed({{4{base[31]}}, base}) + $signed({1'b0, mag});
        end
        if (v > 36'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] f_sat_signed(input logic neg, input logic [33:0] mag);
        if (neg) begin
            if (mag >= 34'h0_8000_0000) begin
                return 32'h8000_0000;
            end
            return 32'(34'd0 - mag);
        end
        if (mag > 34'h0_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end
        return mag[31:0];
    endfunction

    logic [31:0] r_spread, r_opc_x, r_opc_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread <= '0;
            r_opc_x  <= '0;
            r_opc_y  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SPREAD: r_spread <= i_cfg.data;
                CFG_OPC_X:  r_opc_x  <= i_cfg.data;
                CFG_OPC_Y:  r_opc_y  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_ov;

    assign w_en = !r_ov || o_ellipse.ready;
    assign i_sphere.ready = w_en;

    // Front end: products, offsets and hypot operand scaling.
    logic               r_v1, r_v2, r_v3, r_v4;
    t_side              r_s1, r_s2, r_s3, r_s4, n_s1, n_s2, n_s3;
    logic [62:0]        r_prod;
    logic signed [32:0] r_dx, r_dy;
    logic [63:0]        r_tt, n_tt;
    logic [30:0]        r_ha, r_hb, n_ha, n_hb;
    logic [61:0]        r_ha2, r_hb2;
    logic [62:0]        r_hsq;

    always_comb begin
        n_s1      = '0;
        n_s1.par  = (r_spread == '0);
        n_s1.nx   = i_sphere.nominal_x;
        n_s1.ny   = i_sphere.nominal_y;
        n_s1.rin  = i_sphere.nominal_radius;
    end

    always_comb begin
        logic [31:0] t;
        n_s2      = r_s1;
        n_s2.low  = |r_prod[62:FRAC_BITS+32];
        n_s2.negx = r_dx[32];
        n_s2.negy = r_dy[32];
        n_s2.ax   = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
        n_s2.ay   = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
        if (n_s2.ax[32] || n_s2.ay[32]) begin
            n_s2.hs = 2'd2;
        end else if (n_s2.ax[31] || n_s2.ay[31]) begin
            n_s2.hs = 2'd1;
        end else begin
            n_s2.hs = 2'd0;
        end
        n_ha = 31'(n_s2.ax >> n_s2.hs);
        n_hb = 31'(n_s2.ay >> n_s2.hs);
        t    = r_prod[FRAC_BITS+31:FRAC_BITS];
        n_tt = 64'(t) * 64'(t);
    end

    always_comb begin
        n_s3     = r_s2;
        n_s3.den = 33'h1_0000_0000 - {1'b0, r_tt[63:32]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_sphere.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (w_en) begin
            r_s1   <= n_s1;
            r_prod <= 63'(i_sphere.nominal_radius) * 63'(r_spread);
            r_dx   <= $signed({i_sphere.nominal_x[31], i_sphere.nominal_x})
                      - $signed({r_opc_x[31], r_opc_x});
            r_dy   <= $signed({i_sphere.nominal_y[31], i_sphere.nominal_y})
                      - $signed({r_opc_y[31], r_opc_y});
            r_s2   <= n_s2;
            r_tt   <= n_tt;
            r_ha   <= n_ha;
            r_hb   <= n_hb;
            r_s3   <= n_s3;
            r_ha2  <= 62'(r_ha) * 62'(r_ha);
            r_hb2  <= 62'(r_hb) * 62'(r_hb);
            r_s4   <= r_s3;
            r_hsq  <= 63'(r_ha2) + 63'(r_hb2);
        end
    end

    // Square roots of the denominator and of the squared offset length.
    logic                     w_bv;
    logic [1:0][ROOT_W-1:0]   w_broot;
    logic [SW-1:0]            w_bside;
    t_side                    w_sb;

    snae_isqrt #(.L(2), .SW(SW)) u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_rad   ({{1'b0, r_hsq}, {1'b0, r_s4.den, 30'b0}}),
        .i_side  (r_s4),
        .o_valid (w_bv),
        .o_root  (w_broot),
        .o_side  (w_bside)
    );

    assign w_sb = t_side'(w_bside);

    logic  r_v5, r_v6;
    t_side r_s5, r_s6, n_s5, n_s6;
    logic [33:0] r_q, n_q;
    logic [DIV_LANES-1:0][DIV_DW-1:0] r_rem0, r_div, n_rem0, n_div;
    logic [DIV_LANES-1:0][DIV_QW-1:0] r_low, n_low;

    always_comb begin
        logic [65:0] qp;
        n_s5    = w_sb;
        n_s5.sd = w_broot[0];
        n_s5.dd = 34'(w_broot[1]) << w_sb.hs;
        n_s5.dz = (n_s5.dd == '0);
        qp      = 66'(n_s5.dd) * 66'(r_spread);
        n_q     = qp[65:32];
    end

    always_comb begin
        n_s6 = r_s5;
        n_rem0[LN_RAD] = 34'(r_s5.rin >> 4);
        n_low[LN_RAD]  = {r_s5.rin[3:0], 31'b0};
        n_div[LN_RAD]  = 34'(r_s5.sd);
        n_rem0[LN_G]   = 34'(r_q >> 4);
        n_low[LN_G]    = {r_q[3:0], 31'b0};
        n_div[LN_G]    = 34'(r_s5.sd);
        n_rem0[LN_CX]  = 34'(r_s5.ax >> 3);
        n_low[LN_CX]   = {r_s5.ax[2:0], 32'b0};
        n_div[LN_CX]   = 34'(r_s5.den);
        n_rem0[LN_CY]  = 34'(r_s5.ay >> 3);
        n_low[LN_CY]   = {r_s5.ay[2:0], 32'b0};
        n_div[LN_CY]   = 34'(r_s5.den);
        n_rem0[LN_RX]  = 34'(r_s5.ax >> 4);
        n_low[LN_RX]   = {r_s5.ax[3:0], 31'b0};
        n_div[LN_RX]   = r_s5.dd;
        n_rem0[LN_RY]  = 34'(r_s5.ay >> 4);
        n_low[LN_RY]   = {r_s5.ay[3:0], 31'b0};
        n_div[LN_RY]   = r_s5.dd;
        for (int l = 0; l < DIV_LANES; l++) begin
            n_s6.ovf[l] = (n_rem0[l] >= n_div[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_bv;
            r_v6 <= r_v5;
        end
        if (w_en) begin
            r_s5   <= n_s5;
            r_q    <= n_q;
            r_s6   <= n_s6;
            r_rem0 <= n_rem0;
            r_low  <= n_low;
            r_div  <= n_div;
        end
    end

    // Quotients: minor radius, scaled offset length, centre shifts, direction.
    logic                             w_dv;
    logic [DIV_LANES-1:0][DIV_QW-1:0] w_dq;
    logic [SW-1:0]                    w_dside;
    t_side                            w_sd;

    snae_div #(.L(DIV_LANES), .DW(DIV_DW), .QW(DIV_QW), .SW(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_rem0  (r_rem0),
        .i_low   (r_low),
        .i_div   (r_div),
        .i_side  (r_s6),
        .o_valid (w_dv),
        .o_quo   (w_dq),
        .o_side  (w_dside)
    );

    assign w_sd = t_side'(w_dside);

    logic        r_v7, r_v8, r_v9;
    t_side       r_s7, r_s8, r_s9, n_s7;
    logic [30:0] r_ga, r_oa, n_ga, n_oa;
    logic [61:0] r_ga2, r_oa2;
    logic [62:0] r_gsum;

    always_comb begin
        logic [34:0] g;
        logic [34:0] mx, my;
        n_s7 = w_sd;
        if (w_sd.ovf[LN_RAD] || (w_dq[LN_RAD] > 35'h0_7FFF_FFFF)) begin
            n_s7.rsat = 31'h7FFF_FFFF;
        end else begin
            n_s7.rsat = w_dq[LN_RAD][30:0];
        end
        n_s7.gov = w_sd.ovf[LN_G];
        g = w_dq[LN_G];
        if (g[34]) begin
            n_s7.gsh = 3'd4;
        end else if (g[33]) begin
            n_s7.gsh = 3'd3;
        end else if (g[32]) begin
            n_s7.gsh = 3'd2;
        end else if (g[31]) begin
            n_s7.gsh = 3'd1;
        end else begin
            n_s7.gsh = 3'd0;
        end
        n_ga = 31'(g >> n_s7.gsh);
        n_oa = 31'(ONE >> n_s7.gsh);
        if (w_sd.ovf[LN_CX] || (w_dq[LN_CX] > 35'h4_0000_0000)) begin
            mx = 35'h4_0000_0000;
        end else begin
            mx = w_dq[LN_CX];
        end
        if (w_sd.ovf[LN_CY] || (w_dq[LN_CY] > 35'h4_0000_0000)) begin
            my = 35'h4_0000_0000;
        end else begin
            my = w_dq[LN_CY];
        end
        n_s7.appx = f_sat_add(r_opc_x, w_sd.negx, mx);
        n_s7.appy = f_sat_add(r_opc_y, w_sd.negy, my);
        if (w_sd.ovf[LN_RX] || (w_dq[LN_RX] > 35'h0_8000_0000)) begin
            n_s7.rx = 32'h8000_0000;
        end else begin
            n_s7.rx = w_dq[LN_RX][31:0];
        end
        if (w_sd.ovf[LN_RY] || (w_dq[LN_RY] > 35'h0_8000_0000)) begin
            n_s7.ry = 32'h8000_0000;
        end else begin
            n_s7.ry = w_dq[LN_RY][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= w_dv;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
        if (w_en) begin
            r_s7   <= n_s7;
            r_ga   <= n_ga;
            r_oa   <= n_oa;
            r_s8   <= r_s7;
            r_ga2  <= 62'(r_ga) * 62'(r_ga);
            r_oa2  <= 62'(r_oa) * 62'(r_oa);
            r_s9   <= r_s8;
            r_gsum <= 63'(r_ga2) + 63'(r_oa2);
        end
    end

    // Square root for the stretch factor.
    logic                   w_ev;
    logic [0:0][ROOT_W-1:0] w_eroot;
    logic [SW-1:0]          w_eside;
    t_side                  w_se;

    snae_isqrt #(.L(1), .SW(SW)) u_sqrt_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v9),
        .i_rad   ({1'b0, r_gsum}),
        .i_side  (r_s9),
        .o_valid (w_ev),
        .o_root  (w_eroot),
        .o_side  (w_eside)
    );

    assign w_se = t_side'(w_eside);

    logic        r_v10, r_v11, r_v12;
    t_side       r_s10, r_s11, r_s12, n_s10;
    logic [62:0] r_mm;
    logic [64:0] r_px, r_py, n_px, n_py;

    always_comb begin
        logic [35:0] hyp;
        logic [35:0] diff;
        n_s10 = w_se;
        hyp   = 36'(w_eroot[0]) << w_se.gsh;
        diff  = hyp - ONE;
        if (w_se.gov) begin
            n_s10.s = 32'hFFFF_FFFF;
        end else if (hyp > ONE) begin
            n_s10.s = (diff > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
        end else begin
            n_s10.s = '0;
        end
    end

    always_comb begin
        logic [62:0] mt;
        logic [32:0] m;
        mt   = r_mm >> FRAC_BITS;
        m    = (mt > 63'h1_0000_0000) ? 33'h1_0000_0000 : mt[32:0];
        n_px = 65'(m) * 65'(r_s11.rx);
        n_py = 65'(m) * 65'(r_s11.ry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
            r_v11 <= 1'b0;
            r_v12 <= 1'b0;
        end else if (w_en) begin
            r_v10 <= w_ev;
            r_v11 <= r_v10;
            r_v12 <= r_v11;
        end
        if (w_en) begin
            r_s10 <= n_s10;
            r_s11 <= r_s10;
            r_mm  <= 63'(r_s10.s) * 63'(r_s10.rsat);
            r_s12 <= r_s11;
            r_px  <= n_px;
            r_py  <= n_py;
        end
    end

    // Output register.
    logic [31:0] r_app_x, r_app_y, r_str_x, r_str_y, n_app_x, n_app_y, n_str_x, n_str_y;
    logic [30:0] r_minor, n_minor;
    logic        r_too_low, n_too_low;

    always_comb begin
        n_app_x   = '0;
        n_app_y   = '0;
        n_minor   = '0;
        n_str_x   = '0;
        n_str_y   = '0;
        n_too_low = 1'b0;
        if (r_s12.par) begin
            n_app_x = r_s12.nx;
            n_app_y = r_s12.ny;
            n_minor = r_s12.rin;
        end else if (r_s12.low) begin
            n_too_low = 1'b1;
        end else begin
            n_app_x = r_s12.appx;
            n_app_y = r_s12.appy;
            n_minor = r_s12.rsat;
            if (!r_s12.dz) begin
                n_str_x = f_sat_signed(r_s12.negx, r_px[64:31]);
                n_str_y = f_sat_signed(r_s12.negy, r_py[64:31]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_v12;
        end
        if (w_en) begin
            r_app_x   <= n_app_x;
            r_app_y   <= n_app_y;
            r_minor   <= n_minor;
            r_str_x   <= n_str_x;
            r_str_y   <= n_str_y;
            r_too_low <= n_too_low;
        end
    end

    assign o_ellipse.valid          = r_ov;
    assign o_ellipse.apparent_x     = r_app_x;
    assign o_ellipse.apparent_y     = r_app_y;
    assign o_ellipse.minor_radius   = r_minor;
    assign o_ellipse.stretch_x      = r_str_x;
    assign o_ellipse.stretch_y      = r_str_y;
    assign o_ellipse.camera_too_low = r_too_low;

    a_too_low_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_too_low |-> r_minor == '0 && r_app_x == '0 && r_app_y == '0
                              && r_str_x == '0 && r_str_y == '0)
        else $error("flagged beat carries nonzero fields");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_ellipse.ready |-> !i_sphere.ready)
        else $error("input taken while output beat is stalled");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_ov)
        else $error("output valid after reset");

endmodule
`default_nettype wire

// ===== rtl/core/snae_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per register stage over several lanes, with a side vector.
// ----------------------------------------------------------------------------
module snae_isqrt #(
    parameter int L  = 1,
    parameter int SW = 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic [L-1:0][snae_pkg::SQRT_W-1:0]     i_rad,
    input  logic [SW-1:0]                           i_side,
    output logic                                    o_valid,
    output logic [L-1:0][snae_pkg::ROOT_W-1:0]     o_root,
    output logic [SW-1:0]                           o_side
);
    import snae_pkg::*;

    localparam int NS = SQRT_STEPS;

    logic                     w_vld  [0:NS];
    logic [L-1:0][SQRT_W-1:0] w_rem  [0:NS];
    logic [L-1:0][SQRT_W-1:0] w_root [0:NS];
    logic [SW-1:0]            w_side [0:NS];

    assign w_vld[0]  = i_valid;
    assign w_rem[0]  = i_rad;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < NS; s++) begin : g_step
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (NS - 1 - s));
        logic                     r_vld;
        logic [L-1:0][SQRT_W-1:0] r_rem, r_root, n_rem, n_root;
        logic [SW-1:0]            r_side;

        always_comb begin
            for (int l = 0; l < L; l++) begin
                if (w_rem[s][l] >= w_root[s][l] + BIT) begin
                    n_rem[l]  = w_rem[s][l] - (w_root[s][l] + BIT);
                    n_root[l] = (w_root[s][l] >> 1) + BIT;
                end else begin
                    n_rem[l]  = w_rem[s][l];
                    n_root[l] = w_root[s][l] >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_side <= w_side[s];
            end
        end

        assign w_vld[s+1]  = r_vld;
        assign w_rem[s+1]  = r_rem;
        assign w_root[s+1] = r_root;
        assign w_side[s+1] = r_side;
    end

    for (genvar l = 0; l < L; l++) begin : g_out
        assign o_root[l] = w_root[NS][l][ROOT_W-1:0];
    end

    assign o_valid = w_vld[NS];
    assign o_side  = w_side[NS];

endmodule
`default_nettype wire

// ===== rtl/core/snae_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage over several lanes, with a side vector.
// ----------------------------------------------------------------------------
module snae_div #(
    parameter int L  = snae_pkg::DIV_LANES,
    parameter int DW = snae_pkg::DIV_DW,
    parameter int QW = snae_pkg::DIV_QW,
    parameter int SW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [L-1:0][DW-1:0] i_rem0,
    input  logic [L-1:0][QW-1:0] i_low,
    input  logic [L-1:0][DW-1:0] i_div,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [L-1:0][QW-1:0] o_quo,
    output logic [SW-1:0]        o_side
);
    import snae_pkg::*;

    logic                 w_vld  [0:QW];
    logic [L-1:0][DW-1:0] w_rem  [0:QW];
    logic [L-1:0][QW-1:0] w_low  [0:QW];
    logic [L-1:0][DW-1:0] w_div  [0:QW];
    logic [L-1:0][QW-1:0] w_quo  [0:QW];
    logic [SW-1:0]        w_side [0:QW];

    assign w_vld[0]  = i_valid;
    assign w_rem[0]  = i_rem0;
    assign w_low[0]  = i_low;
    assign w_div[0]  = i_div;
    assign w_quo[0]  = '0;
    assign w_side[0] = i_side;

    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int B = QW - 1 - s;
        logic                 r_vld;
        logic [L-1:0][DW-1:0] r_rem, r_div, n_rem;
        logic [L-1:0][QW-1:0] r_low, r_quo, n_quo;
        logic [SW-1:0]        r_side;

        always_comb begin
            logic [DW:0] trial;
            for (int l = 0; l < L; l++) begin
                trial    = {w_rem[s][l], w_low[s][l][B]};
                n_quo[l] = w_quo[s][l];
                if (trial >= {1'b0, w_div[s][l]}) begin
                    n_rem[l]    = DW'(trial - {1'b0, w_div[s][l]});
                    n_quo[l][B] = 1'b1;
                end else begin
                    n_rem[l] = trial[DW-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[s];
            end
            if (i_en) begin
                r_rem  <= n_rem;
                r_low  <= w_low[s];
                r_div  <= w_div[s];
                r_quo  <= n_quo;
                r_side <= w_side[s];
            end
        end

        assign w_vld[s+1]  = r_vld;
        assign w_rem[s+1]  = r_rem;
        assign w_low[s+1]  = r_low;
        assign w_div[s+1]  = r_div;
        assign w_quo[s+1]  = r_quo;
        assign w_side[s+1] = r_side;
    end

    assign o_valid = w_vld[QW];
    assign o_quo   = w_quo[QW];
    assign o_side  = w_side[QW];

endmodule
`default_nettype wire

// ===== tb/snae_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere to ellipse projection checker
// Watches the register, sphere and ellipse channels, computes the expected
// ellipse for every accepted sphere beat and compares the ellipse beats in order.
// ----------------------------------------------------------------------------
module snae_checker
    import snae_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    snae_cfg_if         cfg,
    snae_in_if          sph,
    snae_out_if         ell,
    output int          o_errors,
    output int          o_pending,
    output int          o_flagged,
    output int          o_stretched
);

    typedef bit [63:0] t_u64;

    typedef struct {
        bit signed [DATA_W-1:0] app_x;
        bit signed [DATA_W-1:0] app_y;
        bit        [RAD_W-1:0]  minor;
        bit signed [DATA_W-1:0] str_x;
        bit signed [DATA_W-1:0] str_y;
        bit                     too_low;
    } t_ellipse;

    t_ellipse   ellipse_q[$];
    bit [31:0]  spread_r;
    bit [31:0]  opc_x_r;
    bit [31:0]  opc_y_r;

    function automatic t_u64 root64(t_u64 v);
        t_u64 r;
        t_u64 b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_u64 div_scaled(t_u64 a, int k, t_u64 d);
        return ((a / d) << k) + (((a % d) << k) / d);
    endfunction

    function automatic t_u64 hyp_len(t_u64 a, t_u64 b);
        int sh;
        sh = 0;
        while (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
            a >>= 1;
            b >>= 1;
            sh++;
        end
        return root64(a * a + b * b) << sh;
    endfunction

    function automatic bit [31:0] clamp_mag(bit neg, t_u64 mag);
        if (neg) begin
            if (mag >= 64'h8000_0000) return 32'h8000_0000;
            return 32'(-mag);
        end
        if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic bit [31:0] offset_centre(longint base, bit neg, t_u64 mag);
        longint v;
        if (mag > (t_u64'(1) << 34)) mag = t_u64'(1) << 34;
        v = neg ? base - longint'(mag) : base + longint'(mag);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_ellipse project(bit [31:0] nx_in, bit [31:0] ny_in,
                                         bit [30:0] rad_in);
        t_ellipse e;
        t_u64   radius, prod, t, t2, den, sd, rad, rad_sat, ax, ay, dd, q, g, s, m;
        t_u64   rx, ry, hyp, one;
        longint nx, ny, ox, oy, dx, dy;
        e = '{default: '0};
        radius = t_u64'(rad_in);
        one = t_u64'(1) << FRAC_BITS;
        if (spread_r == 0) begin
            e.app_x = nx_in;
            e.app_y = ny_in;
            e.minor = rad_in;
            return e;
        end
        prod = radius * t_u64'(spread_r);
        if (prod >= (t_u64'(1) << (FRAC_BITS + 32))) begin
            e.too_low = 1'b1;
            return e;
        end
        t = prod >> FRAC_BITS;
        t2 = (t * t) >> 32;
        den = (t_u64'(1) << 32) - t2;
        sd = root64(den << 30);
        rad = (radius << 31) / sd;
        rad_sat = rad > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : rad;
        e.minor = rad_sat[30:0];
        nx = longint'(signed'(nx_in));
        ny = longint'(signed'(ny_in));
        ox = longint'(signed'(opc_x_r));
        oy = longint'(signed'(opc_y_r));
        dx = nx - ox;
        dy = ny - oy;
        ax = t_u64'(dx < 0 ? -dx : dx);
        ay = t_u64'(dy < 0 ? -dy : dy);
        e.app_x = offset_centre(ox, dx < 0, div_scaled(ax, 32, den));
        e.app_y = offset_centre(oy, dy < 0, div_scaled(ay, 32, den));
        dd = hyp_len(ax, ay);
        if (dd == 0) return e;
        q = (dd * (t_u64'(spread_r) >> 16)
             + ((dd * (t_u64'(spread_r) & 64'hFFFF)) >> 16)) >> 16;
        g = div_scaled(q, 31, sd);
        hyp = hyp_len(one, g);
        s = hyp > one ? hyp - one : 0;
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
        m = (s * rad_sat) >> FRAC_BITS;
        if (m > (t_u64'(1) << 32)) m = t_u64'(1) << 32;
        rx = div_scaled(ax, 31, dd);
        ry = div_scaled(ay, 31, dd);
        if (rx > 64'h8000_0000) rx = 64'h8000_0000;
        if (ry > 64'h8000_0000) ry = 64'h8000_0000;
        e.str_x = clamp_mag(dx < 0, (m * rx) >> 31);
        e.str_y = clamp_mag(dy < 0, (m * ry) >> 31);
        return e;
    endfunction

    assign o_pending = ellipse_q.size();

    always @(posedge i_clk) begin
        t_ellipse exp_e;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            spread_r    <= '0;
            opc_x_r     <= '0;
            opc_y_r     <= '0;
            o_errors    <= 0;
            o_flagged   <= 0;
            o_stretched <= 0;
            ellipse_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_SPREAD: spread_r <= cfg.data;
                    CFG_OPC_X:  opc_x_r  <= cfg.data;
                    CFG_OPC_Y:  opc_y_r  <= cfg.data;
                    default: ;
                endcase
            end
            if (sph.valid && sph.ready)
                ellipse_q.push_back(project(sph.nominal_x, sph.nominal_y, sph.nominal_radius));
            if (ell.valid && ell.ready) begin
                if (ellipse_q.size() == 0) begin
                    $error("ellipse beat with nothing expected");
                    errs++;
                end else begin
                    exp_e = ellipse_q.pop_front();
                    if (exp_e.too_low) o_flagged <= o_flagged + 1;
                    if (exp_e.str_x != 0 || exp_e.str_y != 0) o_stretched <= o_stretched + 1;
                    if (ell.apparent_x !== exp_e.app_x) begin
                        $error("apparent_x expected %0d got %0d", exp_e.app_x, ell.apparent_x);
                        errs++;
                    end
                    if (ell.apparent_y !== exp_e.app_y) begin
                        $error("apparent_y expected %0d got %0d", exp_e.app_y, ell.apparent_y);
                        errs++;
                    end
                    if (ell.minor_radius !== exp_e.minor) begin
                        $error("minor_radius expected %0d got %0d", exp_e.minor,
                               ell.minor_radius);
                        errs++;
                    end
                    if (ell.stretch_x !== exp_e.str_x) begin
                        $error("stretch_x expected %0d got %0d", exp_e.str_x, ell.stretch_x);
                        errs++;
                    end
                    if (ell.stretch_y !== exp_e.str_y) begin
                        $error("stretch_y expected %0d got %0d", exp_e.str_y, ell.stretch_y);
                        errs++;
                    end
                    if (ell.camera_too_low !== exp_e.too_low) begin
                        $error("camera_too_low expected %0d got %0d", exp_e.too_low,
                               ell.camera_too_low);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_errors <= o_errors + errs;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sphere to ellipse projection testbench
// Drives directed and random spheres through several camera settings with
// random gaps and output stalls; the checker predicts and compares each beat.
// ----------------------------------------------------------------------------
module tb_top;
    import snae_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, flagged, stretched;
    int   spheres_sent;
    int   settings_run;
    bit   steady;

    snae_cfg_if cfg ();
    snae_in_if  sph ();
    snae_out_if ell ();

    sphere_nominal_to_apparent_ellipse i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_sphere (sph),
        .o_ellipse(ell)
    );

    snae_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .cfg        (cfg),
        .sph        (sph),
        .ell        (ell),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_flagged  (flagged),
        .o_stretched(stretched)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        int p;
        if (steady) return 0;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) ell.ready <= 1'b0;
        else          ell.ready <= (pick_gap() == 0);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_camera(logic [31:0] spr, logic [31:0] ox, logic [31:0] oy);
        sph.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        write_reg(CFG_SPREAD, spr);
        write_reg(CFG_OPC_X, ox);
        write_reg(CFG_OPC_Y, oy);
        settings_run++;
    endtask

    task automatic send_sphere(logic [31:0] x, logic [31:0] y, logic [30:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sph.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sph.valid          <= 1'b1;
        sph.nominal_x      <= x;
        sph.nominal_y      <= y;
        sph.nominal_radius <= r;
        do @(posedge i_clk); while (!sph.ready);
        spheres_sent++;
    endtask

    function automatic logic [30:0] rand_radius(logic [31:0] spr);
        int w;
        logic [30:0] r;
        w = (spr == 0 || $urandom_range(9) == 0) ? $urandom_range(31, 1)
                                                 : $urandom_range(31 - $clog2(spr + 1) + 16, 1);
        if (w > 31) w = 31;
        r = 31'($urandom) & 31'((64'd1 << w) - 1);
        return (r == 0) ? 31'd1 : r;
    endfunction

    function automatic logic [31:0] rand_coord(logic [31:0] centre);
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return centre + 32'($signed($urandom_range(2000)) - 1000);
            2:       return centre + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
            default: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
        endcase
    endfunction

    initial begin
        logic [31:0] spr, ox, oy;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data  = '0;
        sph.valid = 1'b0;
        sph.nominal_x = '0;
        sph.nominal_y = '0;
        sph.nominal_radius = '0;
        spheres_sent = 0;
        settings_run = 0;
        steady = 1'b0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
        send_sphere(32'hFFFF_FFFF, 32'h0000_0000, 31'd0);

        set_camera(32'h0100_0000, 32'h0064_0000, 32'hFFCE_0000);
        send_sphere(32'h0064_0000, 32'hFFCE_0000, 31'h0010_0000);
        send_sphere(32'h0064_0000, 32'hFFCE_0000, 31'd0);
        send_sphere(32'h1000_0000, 32'h2000_0000, 31'h0100_0000);
        send_sphere(32'h1000_0000, 32'h2000_0000, 31'h00FF_FFFF);
        send_sphere(32'h1000_0000, 32'h2000_0000, 31'h7FFF_FFFF);
        send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 31'h00FF_0000);
        send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_1000);
        send_sphere(32'h0065_0000, 32'hFFCE_0000, 31'h00F0_0000);

        set_camera(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 31'd1);
        send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 31'h0000_FFFF);
        send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 31'h0000_8000);
        send_sphere(32'h0000_0000, 32'h0000_0000, 31'h0001_0000);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin spr = 32'd1; ox = '0; oy = '0; end
                1: begin spr = 32'h0000_0000; ox = $urandom; oy = $urandom; end
                2: begin spr = 32'h8000_0000; ox = 32'h8000_0000; oy = 32'h7FFF_FFFF; end
                default: begin
                    spr = $urandom >> $urandom_range(16);
                    ox = {{12{1'($urandom_range(1))}}, 20'($urandom)};
                    oy = {{12{1'($urandom_range(1))}}, 20'($urandom)};
                end
            endcase
            set_camera(spr, ox, oy);
            steady = (ph == 4);
            for (int k = 0; k < 150; k++)
                send_sphere(rand_coord(ox), rand_coord(oy), rand_radius(spr));
            steady = 1'b0;
        end
        sph.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        $display("Sent %0d spheres over %0d camera settings.", spheres_sent, settings_run);
        $display("%0d spheres were flagged too close, %0d gave a nonzero stretch.",
                 flagged, stretched);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
`default_nettype wire
